FILE: sv/mdf_pkg.sv
package mdf_pkg;

	localparam int unsigned FieldW = 30;
	localparam logic [FieldW-1:0] Modulus = 30'd1000000007;
	localparam logic [FieldW-1:0] FermatExp = 30'd1000000005;
	localparam logic [31:0] Modulus2x = 32'd2000000014;

	// floor(2^60 / p), fits in 31 bits
	localparam logic [63:0] BarrettWide = (64'd1 << 60) / 64'd1000000007;
	localparam logic [30:0] BarrettM = BarrettWide[30:0];

	localparam int unsigned MulLat = 5;
	localparam int unsigned NumSteps = FieldW;
	localparam int unsigned DivTap = 1 + NumSteps * MulLat;
	localparam int unsigned Depth = DivTap + MulLat;

	typedef struct packed {
		logic [FieldW-1:0] dividend;
		logic [FieldW-1:0] divisor;
	} in_t;

	typedef struct packed {
		logic [FieldW-1:0] quotient;
		logic              zero_divisor;
	} out_t;

endpackage

FILE: sv/mdf_modmul.sv
module mdf_modmul
	import mdf_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [FieldW-1:0] a,
	input  logic [FieldW-1:0] b,
	output logic [FieldW-1:0] y
);

	logic [59:0] prod_s1;
	logic [61:0] t_s2;
	logic [31:0] plo_s2, plo_s3, qp_s3, r_s4;
	logic [30:0] q;
	logic [61:0] qp_full;
	logic [FieldW-1:0] y_s5;

	assign q = t_s2[61:31];
	assign qp_full = 62'(q) * 62'(Modulus);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 60'(a) * 60'(b);
			t_s2    <= 62'(prod_s1[59:29]) * 62'(BarrettM);
			plo_s2  <= prod_s1[31:0];
			qp_s3   <= qp_full[31:0];
			plo_s3  <= plo_s2;
			// Barrett estimate is short by at most two multiples of p
			r_s4    <= plo_s3 - qp_s3;
			if (r_s4 >= Modulus2x)
				y_s5 <= FieldW'(r_s4 - Modulus2x);
			else if (r_s4 >= 32'(Modulus))
				y_s5 <= FieldW'(r_s4 - 32'(Modulus));
			else
				y_s5 <= r_s4[FieldW-1:0];
		end
	end

	assign y = y_s5;

endmodule

FILE: sv/modular_division_fermat_core.sv
// Modular division over the prime field p = 1000000007.
// in channel (in_valid/in_ready/in_data) carries a dividend and a divisor;
// out channel (out_valid/out_ready/out_data) returns dividend * divisor^(p-2)
// mod p and a zero_divisor flag. Operands of p or more are reduced first.
// A zero divisor gives quotient 0 with zero_divisor set.
// The pipeline has one reduction stage, thirty square-and-multiply
// steps of five stages each (one pipelined Barrett multiplier per product),
// and a final five-stage multiply by the dividend.
// Throughput is one transaction per cycle. The whole pipeline advances
// together; when the receiver stalls with a result waiting, every stage
// holds and in_ready drops, so nothing is lost or repeated.
// Reset clears the stage valid bits only; the pipe then accepts at once.
module modular_division_fermat_core
	import mdf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic              adv;
	logic [Depth-1:0]  vld_q;
	logic [Depth-1:0]  zero_q;
	logic [FieldW-1:0] div_q [DivTap];
	logic [FieldW-1:0] sq [NumSteps];
	logic [FieldW-1:0] acc [NumSteps+1];
	logic [FieldW-1:0] red_div, red_dvd, quot;

	assign adv = !vld_q[Depth-1] || out_ready;
	assign in_ready = adv;

	assign red_div = (in_data.divisor >= Modulus) ? in_data.divisor - Modulus
		: in_data.divisor;
	assign red_dvd = (in_data.dividend >= Modulus) ? in_data.dividend - Modulus
		: in_data.dividend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_q <= {zero_q[Depth-2:0], red_div == '0};
			div_q[0] <= red_dvd;
			sq[0]    <= red_div;
			for (int i = 1; i < DivTap; i++)
				div_q[i] <= div_q[i-1];
		end
	end

	assign acc[0] = FieldW'(1);

	for (genvar i = 0; i < NumSteps; i++) begin : g_step
		mdf_modmul u_acc (
			.clk(clk),
			.en (adv),
			.a  (acc[i]),
			.b  (FermatExp[i] ? sq[i] : FieldW'(1)),
			.y  (acc[i+1])
		);
		if (i < NumSteps - 1) begin : g_sq
			mdf_modmul u_sq (
				.clk(clk),
				.en (adv),
				.a  (sq[i]),
				.b  (sq[i]),
				.y  (sq[i+1])
			);
		end
	end

	mdf_modmul u_final (
		.clk(clk),
		.en (adv),
		.a  (acc[NumSteps]),
		.b  (div_q[DivTap-1]),
		.y  (quot)
	);

	assign out_valid = vld_q[Depth-1];
	assign out_data.quotient = quot;
	assign out_data.zero_divisor = zero_q[Depth-1];

endmodule

FILE: dv/modular_division_fermat_checker.sv
module modular_division_fermat_checker
	import mdf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] Prime = 64'd1000000007;

	out_t quotient_q[$];

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b);
		return (a * b) % Prime;
	endfunction

	function automatic out_t divide_mod(in_t item);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] acc;
		logic [63:0] sq;
		logic [31:0] e;
		out_t r;
		num = {34'd0, item.dividend} % Prime;
		den = {34'd0, item.divisor} % Prime;
		acc = 64'd1;
		sq = den;
		e = 32'(Prime - 64'd2);
		while (e != 0) begin
			if (e[0])
				acc = mul_mod(acc, sq);
			sq = mul_mod(sq, sq);
			e = e >> 1;
		end
		r.quotient = FieldW'(mul_mod(acc, num));
		r.zero_divisor = (den == 0);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = quotient_q.size();

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				quotient_q.push_back(divide_mod(in_data));
			if (out_valid && out_ready) begin
				if (quotient_q.size() == 0) begin
					report("unexpected transaction", out_data.quotient, 0);
				end else begin
					want = quotient_q.pop_front();
					if (out_data.quotient !== want.quotient)
						report("quotient", out_data.quotient, want.quotient);
					if (out_data.zero_divisor !== want.zero_divisor)
						report("zero_divisor", out_data.zero_divisor, want.zero_divisor);
				end
			end
		end
	end
endmodule

FILE: dv/modular_division_fermat_core_test.sv
module modular_division_fermat_core_test;
	import mdf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RandItems = 1750;
	localparam int unsigned CycleLimit = 400000;
	localparam logic [FieldW-1:0] Top = 30'h3FFFFFFF;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_t out_data;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	bit   long_hold = 0;
	bit   done = 0;
	int   zero_seen = 0;

	always #1 clk = ~clk;

	modular_division_fermat_core uut (.*);

	modular_division_fermat_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// receiver: own stall pattern, plus a long hold-off once
	always @(posedge clk) begin
		if (long_hold)
			out_ready <= 0;
		else if ($urandom_range(0, 3) == 0)
			out_ready <= ($urandom_range(0, 1) == 1);
		else if (cycles % 512 < 128)
			out_ready <= 1;
	end

	// in_ready is settled by the falling edge; accept happens at the next rising edge
	task automatic send(logic [FieldW-1:0] a, logic [FieldW-1:0] b);
		in_valid <= 1;
		in_data <= '{dividend: a, divisor: b};
		if (b == 0 || b == Modulus)
			zero_seen++;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [FieldW-1:0] pick();
		case ($urandom_range(0, 9))
			0: return Top - FieldW'($urandom_range(0, 3));
			1: return Modulus + FieldW'($urandom_range(0, 2)) - 30'd1;
			2: return FieldW'($urandom_range(0, 2));
			3: return Modulus - 30'd1 - FieldW'($urandom_range(0, 2));
			default: return FieldW'($urandom_range(0, 1000000006));
		endcase
	endfunction

	task automatic idle(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int burst;
		int hold;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: field extremes, zero divisor both forms, out-of-range operands
		send(30'd0, 30'd1);
		send(30'd1, 30'd1);
		send(Modulus - 30'd1, Modulus - 30'd1);
		send(30'd12345, 30'd0);
		send(30'd0, 30'd0);
		send(30'd777, Modulus);
		send(Top, 30'd0);
		send(Top, Top);
		send(Modulus, 30'd2);
		send(Modulus + 30'd1, Modulus + 30'd1);
		send(30'd1, 30'd2);
		send(30'h2AAAAAAA, 30'h15555555);
		send(30'h15555555, 30'h2AAAAAAA);
		send(Top, 30'd1);
		send(30'd1, Top);
		send(Modulus - 30'd1, 30'd2);
		// hold the receiver off so the pipeline fills and in_ready drops
		long_hold = 1;
		fork
			begin
				hold = 0;
				while (hold < 400) begin
					@(posedge clk);
					hold++;
				end
				long_hold = 0;
			end
			for (int i = 0; i < 200; i++)
				send(FieldW'($urandom), FieldW'($urandom));
		join
		// pause until all outstanding results are back
		in_valid <= 0;
		drain();
		for (int n = 0; n < RandItems; n += burst) begin
			burst = $urandom_range(1, 60);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(0, 3) == 0)
					send(FieldW'($urandom), FieldW'($urandom));
				else
					send(pick(), pick());
			end
			if ($urandom_range(0, 2) != 0)
				idle($urandom_range(1, 20));
		end
		in_valid <= 0;
		drain();
		repeat (Depth + 20) @(posedge clk);
		$display("covered %0d cycles, zero divisors sent: %0d", cycles, zero_seen);
		$display("directed extremes, long receiver hold-off and random bursts done");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
